[sv/lspd_pkg.sv]
// Shared types, constants and helper functions for the line sensor PD steering block.
package lspd_pkg;

  // Fixed field widths
  localparam int NUM_PORTS  = 8;
  localparam int THR_W      = 12;
  localparam int GAIN_W     = 7;
  localparam int DUTY_W     = 8;
  localparam int ERR_W      = 7;
  localparam int SUM_W      = 8;
  localparam int CNT_W      = 4;
  localparam int STEP_W     = 3;
  localparam int PD_W       = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // One quotient bit is resolved per divide step
  localparam int DIV_STEPS = ERR_W;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 12'd3200;
  localparam logic [GAIN_W-1:0] GAIN_LIMIT      = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_MAX        = 8'd255;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_OUT
  } lspd_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              load;
    logic              scan;
    logic [STEP_W-1:0] idx;
    logic              div_init;
    logic              div_step;
    logic              err_sel;
    logic              mul_p;
    logic              mul_d;
    logic              out_load;
  } lspd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic line_seen;
  } lspd_status_t;

  // Sensor position weights, leftmost to rightmost
  function automatic logic signed [SUM_W-1:0] sensor_weight(input logic [STEP_W-1:0] idx);
    logic signed [SUM_W-1:0] w;
    case (idx)
      3'd0:    w = -8'sd50;
      3'd1:    w = -8'sd20;
      3'd2:    w = -8'sd10;
      3'd3:    w = -8'sd5;
      3'd4:    w = 8'sd5;
      3'd5:    w = 8'sd10;
      3'd6:    w = 8'sd20;
      3'd7:    w = 8'sd50;
      default: w = 8'sd0;
    endcase
    return w;
  endfunction

  // Limit a gain or speed write to the legal range
  function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] v);
    return (v > GAIN_LIMIT) ? GAIN_LIMIT : v;
  endfunction

  // Clamp a signed duty sum to 0..255
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [PD_W-1:0] v);
    logic [DUTY_W-1:0] d;
    if (v < 0) begin
      d = '0;
    end else if (v > PD_W'(DUTY_MAX)) begin
      d = DUTY_MAX;
    end else begin
      d = v[DUTY_W-1:0];
    end
    return d;
  endfunction

endpackage

[sv/line_sensor_pd_steering_top.sv]
// Line sensor PD steering block: top level joining the controller and the datapath.
//
// Usage: each input word on in_* is one scan of eight reflectance samples; each
// result word on out_* carries the left and right duties, the line error used
// and a flag that some sensor saw the line. Both channels use valid/stall: a
// word moves at a clock edge with valid high and stall low.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 threshold,
// 1 proportional gain, 2 derivative gain, 3 base speed). The user must write only
// while the block is idle; the block itself does not enforce this.
// Order of work: the word is captured, the sensors are scanned one per cycle,
// the seven-step divider runs (skipped when no sensor sees the line), then the
// error is selected, the P and D products are formed and the result loaded.
// in_stall is high for the whole time a word is being worked.
// Reset (rst_n low, synchronous) loads threshold 3200, clears gains, speed and
// the stored error, and empties the output register.
// A stalled result stays in the output register; the next word is still
// taken and worked, and waits in its final step until the register frees.
module line_sensor_pd_steering_top import lspd_pkg::*; #(
  parameter int NUM_SENSORS = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample_0,
  input  logic [SAMPLE_BITS-1:0]  in_sample_1,
  input  logic [SAMPLE_BITS-1:0]  in_sample_2,
  input  logic [SAMPLE_BITS-1:0]  in_sample_3,
  input  logic [SAMPLE_BITS-1:0]  in_sample_4,
  input  logic [SAMPLE_BITS-1:0]  in_sample_5,
  input  logic [SAMPLE_BITS-1:0]  in_sample_6,
  input  logic [SAMPLE_BITS-1:0]  in_sample_7,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DUTY_W-1:0]       out_left_duty,
  output logic [DUTY_W-1:0]       out_right_duty,
  output logic signed [ERR_W-1:0] out_line_error,
  output logic                    out_line_seen
);

  lspd_cmd_t    cmd;
  lspd_status_t status;

  lspd_ctrl #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lspd_datapath #(
    .NUM_SENSORS(NUM_SENSORS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_sample_0   (in_sample_0),
    .in_sample_1   (in_sample_1),
    .in_sample_2   (in_sample_2),
    .in_sample_3   (in_sample_3),
    .in_sample_4   (in_sample_4),
    .in_sample_5   (in_sample_5),
    .in_sample_6   (in_sample_6),
    .in_sample_7   (in_sample_7),
    .cmd           (cmd),
    .status        (status),
    .out_left_duty (out_left_duty),
    .out_right_duty(out_right_duty),
    .out_line_error(out_line_error),
    .out_line_seen (out_line_seen)
  );

  // A taken input word blocks the next one until its work is done
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back while busy");

  // The output word only appears after an output load
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a load");

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // At most one datapath step per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.div_init, cmd.div_step, cmd.err_sel,
              cmd.mul_p, cmd.mul_d, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

[sv/lspd_ctrl.sv]
// Sequencing controller: walks one scan through compare, divide, PD and output load.
module lspd_ctrl import lspd_pkg::*; #(
  parameter int NUM_SENSORS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  lspd_status_t status,
  output lspd_cmd_t    cmd
);

  localparam int NUM_USED = (NUM_SENSORS < NUM_PORTS) ? NUM_SENSORS : NUM_PORTS;
  localparam logic [STEP_W-1:0] LAST_IDX  = STEP_W'(NUM_USED - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  lspd_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, step counter and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV_INIT: begin
        // skip the divide when no sensor saw the line
        if (status.line_seen) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_ERR;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_ERR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ERR: begin
        cmd.err_sel = 1'b1;
        state_nxt   = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[sv/lspd_datapath.sv]
// Datapath: config registers, sensor scan, serial divider, PD multiply and clamped outputs.
module lspd_datapath import lspd_pkg::*; #(
  parameter int NUM_SENSORS = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]       in_sample_0,
  input  logic [SAMPLE_BITS-1:0]       in_sample_1,
  input  logic [SAMPLE_BITS-1:0]       in_sample_2,
  input  logic [SAMPLE_BITS-1:0]       in_sample_3,
  input  logic [SAMPLE_BITS-1:0]       in_sample_4,
  input  logic [SAMPLE_BITS-1:0]       in_sample_5,
  input  logic [SAMPLE_BITS-1:0]       in_sample_6,
  input  logic [SAMPLE_BITS-1:0]       in_sample_7,
  input  lspd_cmd_t                    cmd,
  output lspd_status_t                 status,
  output logic [DUTY_W-1:0]            out_left_duty,
  output logic [DUTY_W-1:0]            out_right_duty,
  output logic signed [ERR_W-1:0]      out_line_error,
  output logic                         out_line_seen
);

  localparam int NUM_USED = (NUM_SENSORS < NUM_PORTS) ? NUM_SENSORS : NUM_PORTS;
  localparam int IDX_W    = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;
  localparam int CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [THR_W-1:0]         thr_r;
  logic [GAIN_W-1:0]        kp_r;
  logic [GAIN_W-1:0]        kd_r;
  logic [GAIN_W-1:0]        base_r;

  logic [SAMPLE_BITS-1:0]   in_arr   [NUM_PORTS];
  logic [SAMPLE_BITS-1:0]   sample_r [NUM_USED];
  logic [SAMPLE_BITS-1:0]   cur_sample;
  logic                     hit;
  logic signed [SUM_W-1:0]  weight;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         count_r;

  logic signed [SUM_W-1:0]  sum_abs;
  logic                     neg_r;
  logic [ERR_W-1:0]         q_r, q_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;

  logic signed [ERR_W-1:0]  quo_s;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  prev_error_r;
  logic signed [PD_W-1:0]   kp_ext, kd_ext, base_ext, err_ext, diff_ext;
  logic signed [PD_W-1:0]   prod_p_r;
  logic signed [PD_W-1:0]   pd_r;
  logic signed [PD_W-1:0]   left_sum, right_sum;

  // Configuration registers, gains and speed saturated on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      kp_r   <= '0;
      kd_r   <= '0;
      base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:  thr_r  <= cfg_wdata[THR_W-1:0];
        REG_PROP_GAIN:  kp_r   <= sat_gain(cfg_wdata[GAIN_W-1:0]);
        REG_DERIV_GAIN: kd_r   <= sat_gain(cfg_wdata[GAIN_W-1:0]);
        REG_BASE_SPEED: base_r <= sat_gain(cfg_wdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  assign in_arr[0] = in_sample_0;
  assign in_arr[1] = in_sample_1;
  assign in_arr[2] = in_sample_2;
  assign in_arr[3] = in_sample_3;
  assign in_arr[4] = in_sample_4;
  assign in_arr[5] = in_sample_5;
  assign in_arr[6] = in_sample_6;
  assign in_arr[7] = in_sample_7;

  // Capture the scan when the word is accepted
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_USED; i++) begin
        sample_r[i] <= in_arr[i];
      end
    end
  end

  // One sensor per scan step: compare and accumulate
  assign cur_sample = sample_r[cmd.idx[IDX_W-1:0]];
  assign hit        = CMP_W'(cur_sample) > CMP_W'(thr_r);
  assign weight     = sensor_weight(cmd.idx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.scan && hit) begin
      sum_r   <= sum_r + weight;
      count_r <= count_r + 1'b1;
    end
  end

  assign status.line_seen = (count_r != '0);

  // Restoring divide of |sum| by count, one quotient bit per step
  assign sum_abs  = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign trial    = {rem_r, q_r[ERR_W-1]};
  assign trial_ge = trial >= {1'b0, count_r};

  always_comb begin
    q_nxt   = {q_r[ERR_W-2:0], trial_ge};
    rem_nxt = trial_ge ? CNT_W'(trial - {1'b0, count_r}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r <= sum_r[SUM_W-1];
      q_r   <= sum_abs[ERR_W-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Signed quotient truncates toward zero; hold the old error when blind
  assign quo_s = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (cmd.err_sel) begin
      err_r <= status.line_seen ? quo_s : prev_error_r;
    end
  end

  // PD term: P product registered first, then P plus D product
  assign kp_ext   = PD_W'($signed({1'b0, kp_r}));
  assign kd_ext   = PD_W'($signed({1'b0, kd_r}));
  assign base_ext = PD_W'($signed({1'b0, base_r}));
  assign err_ext  = PD_W'(err_r);
  assign diff_ext = err_ext - PD_W'(prev_error_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_p) begin
      prod_p_r <= kp_ext * err_ext;
    end
    if (cmd.mul_d) begin
      pd_r <= prod_p_r + kd_ext * diff_ext;
    end
  end

  // Duties and output word
  assign left_sum  = base_ext + pd_r;
  assign right_sum = base_ext - pd_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_duty  <= clamp_duty(left_sum);
      out_right_duty <= clamp_duty(right_sum);
      out_line_error <= err_r;
      out_line_seen  <= status.line_seen;
    end
  end

  // Error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
    end else if (cmd.out_load) begin
      prev_error_r <= err_r;
    end
  end

endmodule
